@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL. Synthesis builds define SYNTH so that
// every assertion drops out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT(label, prop, msg) \
  `ASSERT_AT(label, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT(label, prop, msg)
`endif

`endif

@@ rtl/core/lfd_pkg.sv @@
package lfd_pkg;

  localparam int unsigned LvlW       = 11;
  localparam int unsigned MsW        = 16;
  localparam int unsigned FullScale  = 1024;
  localparam int unsigned ResetLevel = 0;

  localparam logic [LvlW-1:0] FullLvl  = LvlW'(FullScale);
  localparam logic [LvlW-1:0] ResetLvl =
      (ResetLevel > FullScale) ? LvlW'(FullScale) : LvlW'(ResetLevel);
  localparam logic [MsW-1:0]  SpeedRst = MsW'(10);
  localparam logic [MsW-1:0]  MsMax    = {MsW{1'b1}};

  // Command codes.
  localparam logic [3:0] CmdTick   = 4'd0;
  localparam logic [3:0] CmdOn     = 4'd1;
  localparam logic [3:0] CmdOff    = 4'd2;
  localparam logic [3:0] CmdDim    = 4'd3;
  localparam logic [3:0] CmdDimTo  = 4'd4;
  localparam logic [3:0] CmdSetDim = 4'd5;
  localparam logic [3:0] CmdFlash  = 4'd6;
  localparam logic [3:0] CmdPulse  = 4'd7;
  localparam logic [3:0] CmdStop   = 4'd8;

  typedef enum logic [2:0] {
    ModeOn    = 3'd0,
    ModeOff   = 3'd1,
    ModeDim   = 3'd2,
    ModeDimTo = 3'd3,
    ModeFlash = 3'd4,
    ModePulse = 3'd5
  } lfd_mode_e;

  typedef struct packed {
    logic [3:0]      cmd;
    logic [LvlW-1:0] level;
  } lfd_req_t;

  typedef struct packed {
    logic [LvlW-1:0] brightness;
    logic [LvlW-1:0] pwm_low_time;
    logic [2:0]      mode;
    logic            stepped;
  } lfd_res_t;

  typedef struct packed {
    logic [LvlW-1:0] cur;
    logic [LvlW-1:0] tgt;
    logic            down;
    lfd_mode_e       mode;
    logic [MsW-1:0]  elapsed;
    logic [LvlW-1:0] drive;
  } lfd_state_t;

endpackage

@@ rtl/core/lfd_step.sv @@
// Next state and result for one request, from the current state.
module lfd_step (
  input  lfd_pkg::lfd_state_t     state_i,
  input  logic [lfd_pkg::MsW-1:0] speed_i,
  input  lfd_pkg::lfd_req_t       req_i,
  output lfd_pkg::lfd_state_t     state_o,
  output lfd_pkg::lfd_res_t       res_o
);

  logic [lfd_pkg::LvlW-1:0] lvl;
  logic [lfd_pkg::MsW-1:0]  elapsed_inc;
  logic                     fading;
  logic                     do_step;
  logic                     pulse_down;
  logic                     move_down;
  logic [lfd_pkg::LvlW-1:0] moved;
  logic                     at_bottom;
  logic                     at_top;
  lfd_pkg::lfd_state_t      stepped_st;
  lfd_pkg::lfd_state_t      nxt;

  assign lvl = (req_i.level > lfd_pkg::FullLvl) ? lfd_pkg::FullLvl : req_i.level;
  assign elapsed_inc = (state_i.elapsed != lfd_pkg::MsMax) ?
                       state_i.elapsed + 1'b1 : state_i.elapsed;
  assign fading  = (state_i.mode != lfd_pkg::ModeOn) && (state_i.mode != lfd_pkg::ModeOff);
  assign do_step = fading && (elapsed_inc >= speed_i);

  // A pulse turns around at zero and at its peak before it moves.
  always_comb begin
    if (state_i.cur == '0) begin
      pulse_down = 1'b0;
    end else if (state_i.cur == state_i.tgt) begin
      pulse_down = 1'b1;
    end else begin
      pulse_down = state_i.down;
    end
  end

  assign move_down = (state_i.mode == lfd_pkg::ModePulse) ? pulse_down : state_i.down;

  always_comb begin
    if (move_down) begin
      moved = (state_i.cur != '0) ? state_i.cur - 1'b1 : state_i.cur;
    end else begin
      moved = (state_i.cur >= lfd_pkg::FullLvl) ? lfd_pkg::FullLvl : state_i.cur + 1'b1;
    end
  end

  assign at_bottom = state_i.down && (state_i.cur == '0);
  assign at_top    = !state_i.down && (state_i.cur >= lfd_pkg::FullLvl);

  always_comb begin
    stepped_st = state_i;
    case (state_i.mode)
      lfd_pkg::ModePulse: begin
        stepped_st.down = pulse_down;
        stepped_st.cur  = moved;
      end
      lfd_pkg::ModeDim, lfd_pkg::ModeDimTo: begin
        stepped_st.cur = moved;
        if (at_bottom || moved == '0) begin
          stepped_st.mode = lfd_pkg::ModeOff;
        end else if (at_top || moved >= lfd_pkg::FullLvl || moved == state_i.tgt) begin
          stepped_st.mode = lfd_pkg::ModeOn;
        end
      end
      lfd_pkg::ModeFlash: begin
        stepped_st.cur = (state_i.cur == '0) ? state_i.tgt : '0;
      end
      default: begin
      end
    endcase
    stepped_st.drive = stepped_st.cur;
  end

  always_comb begin
    nxt = state_i;
    case (req_i.cmd)
      lfd_pkg::CmdTick: begin
        nxt.elapsed = elapsed_inc;
        if (do_step) begin
          nxt         = stepped_st;
          nxt.elapsed = '0;
        end
      end
      lfd_pkg::CmdOn: begin
        nxt.cur   = lfd_pkg::FullLvl;
        nxt.drive = lfd_pkg::FullLvl;
        nxt.mode  = lfd_pkg::ModeOn;
      end
      lfd_pkg::CmdOff: begin
        nxt.cur   = '0;
        nxt.drive = '0;
        nxt.mode  = lfd_pkg::ModeOff;
      end
      lfd_pkg::CmdDim: begin
        if (state_i.cur != '0) begin
          nxt.tgt  = '0;
          nxt.down = 1'b1;
          nxt.mode = lfd_pkg::ModeDim;
        end
      end
      lfd_pkg::CmdDimTo: begin
        nxt.tgt  = lvl;
        nxt.down = lvl < state_i.cur;
        nxt.mode = lfd_pkg::ModeDimTo;
      end
      lfd_pkg::CmdSetDim: begin
        nxt.cur   = lvl;
        nxt.tgt   = lvl;
        nxt.drive = lvl;
      end
      lfd_pkg::CmdFlash, lfd_pkg::CmdPulse: begin
        nxt.cur  = (state_i.cur == '0) ? lfd_pkg::FullLvl : state_i.cur;
        nxt.tgt  = nxt.cur;
        nxt.mode = (req_i.cmd == lfd_pkg::CmdFlash) ? lfd_pkg::ModeFlash : lfd_pkg::ModePulse;
      end
      lfd_pkg::CmdStop: begin
        nxt.mode = lfd_pkg::ModeOn;
      end
      default: begin
      end
    endcase
  end

  assign state_o            = nxt;
  assign res_o.brightness   = nxt.cur;
  assign res_o.pwm_low_time = lfd_pkg::FullLvl - nxt.drive;
  assign res_o.mode         = nxt.mode;
  assign res_o.stepped      = (req_i.cmd == lfd_pkg::CmdTick) && do_step;

endmodule

@@ rtl/core/lamp_fade_dimmer.sv @@
// Channel    Direction  Payload             Handshake
// in         request    lfd_req_t           in_valid_i / in_ready_o
// out        result     lfd_res_t           out_valid_o / out_ready_i
// cfg        write      speed_ms, 16 bits   cfg_valid_i / cfg_ready_o
//
// Every request yields one registered result in the cycle after it is accepted.
// A request is taken in every cycle while the result register is empty or
// is being drained in the same cycle; the lamp state and the result
// register are written together by one pass of combinational logic.
// A stall on the output holds the result register and stops intake.
// Reset (rst_ni low) sets speed_ms to 10, the lamp to mode on at the
// reset level, and empties the result register.
`include "assert_macros.svh"

module lamp_fade_dimmer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lfd_pkg::lfd_req_t        in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output lfd_pkg::lfd_res_t        out_res_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [lfd_pkg::MsW-1:0]  cfg_data_i
);

  // Fade step period in ticks; the user must write it only while the block is idle; the block has no check.
  logic [lfd_pkg::MsW-1:0] speed_q;

  // Lamp state: level, target, direction, mode, tick counter and drive.
  lfd_pkg::lfd_state_t state_q, state_d;

  // Result register with its valid flag.
  lfd_pkg::lfd_res_t res_q, res_d;
  logic              out_valid_q;

  logic in_acc;

  // The configuration write is always taken.
  assign cfg_ready_o = 1'b1;

  // Intake continues while the result is empty or leaving this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  lfd_step u_step (
    .state_i (state_q),
    .speed_i (speed_q),
    .req_i   (in_req_i),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= lfd_pkg::SpeedRst;
    end else if (cfg_valid_i) begin
      speed_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cur     <= lfd_pkg::ResetLvl;
      state_q.tgt     <= '0;
      state_q.down    <= 1'b0;
      state_q.mode    <= lfd_pkg::ModeOn;
      state_q.elapsed <= '0;
      state_q.drive   <= lfd_pkg::ResetLvl;
      out_valid_q     <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // Every accepted request leaves a result waiting in the next cycle.
  `ASSERT(a_acc_gives_result, in_acc |=> out_valid_q, "accepted request left no result")
  // Levels reported never exceed full scale.
  `ASSERT(a_bright_range, out_valid_q |-> res_q.brightness <= lfd_pkg::FullLvl,
          "brightness above full scale")
  `ASSERT(a_pwm_range, out_valid_q |-> res_q.pwm_low_time <= lfd_pkg::FullLvl,
          "pwm low time above full scale")
  // A reported fade step has just cleared the tick counter.
  `ASSERT(a_step_clears, (out_valid_q && res_q.stepped) |-> state_q.elapsed == '0,
          "fade step did not clear the tick counter")

endmodule
